>>> rtl/core/lpe_pkg.sv
package lpe_pkg;

  // Number format and limits
  localparam int FRAC_BITS = 30;
  localparam int MAX_ORDER = 64;
  localparam int ORDER_W   = 7;
  localparam int X_W       = 32;
  localparam int DP_W      = 43;

  // 1.0 in Q1.30, as a magnitude and as a signed point value
  localparam int                       ONE_I    = 1 << FRAC_BITS;
  localparam logic [FRAC_BITS:0]       ONE_MAG  = (FRAC_BITS + 1)'(ONE_I);
  localparam logic signed [X_W-1:0]    ONE_X    = X_W'(ONE_I);

  // Magnitude widths of the recurrence term and of the derivative numerator
  localparam int T_W       = 38;
  localparam int A_W       = 38;
  // Restoring divider: numerator magnitude followed by FRAC_BITS + 1 fraction bits
  localparam int QUO_W     = A_W + FRAC_BITS + 1;
  localparam int DIV_CNT_W = 7;

  // Rounded reciprocals 1/k in Q1.30, k = 0..MAX_ORDER (entry 0 unused)
  localparam int RECIP_TAB [0:MAX_ORDER] = '{
    0,
    (ONE_I + 0) / 1,   (ONE_I + 1) / 2,   (ONE_I + 1) / 3,   (ONE_I + 2) / 4,
    (ONE_I + 2) / 5,   (ONE_I + 3) / 6,   (ONE_I + 3) / 7,   (ONE_I + 4) / 8,
    (ONE_I + 4) / 9,   (ONE_I + 5) / 10,  (ONE_I + 5) / 11,  (ONE_I + 6) / 12,
    (ONE_I + 6) / 13,  (ONE_I + 7) / 14,  (ONE_I + 7) / 15,  (ONE_I + 8) / 16,
    (ONE_I + 8) / 17,  (ONE_I + 9) / 18,  (ONE_I + 9) / 19,  (ONE_I + 10) / 20,
    (ONE_I + 10) / 21, (ONE_I + 11) / 22, (ONE_I + 11) / 23, (ONE_I + 12) / 24,
    (ONE_I + 12) / 25, (ONE_I + 13) / 26, (ONE_I + 13) / 27, (ONE_I + 14) / 28,
    (ONE_I + 14) / 29, (ONE_I + 15) / 30, (ONE_I + 15) / 31, (ONE_I + 16) / 32,
    (ONE_I + 16) / 33, (ONE_I + 17) / 34, (ONE_I + 17) / 35, (ONE_I + 18) / 36,
    (ONE_I + 18) / 37, (ONE_I + 19) / 38, (ONE_I + 19) / 39, (ONE_I + 20) / 40,
    (ONE_I + 20) / 41, (ONE_I + 21) / 42, (ONE_I + 21) / 43, (ONE_I + 22) / 44,
    (ONE_I + 22) / 45, (ONE_I + 23) / 46, (ONE_I + 23) / 47, (ONE_I + 24) / 48,
    (ONE_I + 24) / 49, (ONE_I + 25) / 50, (ONE_I + 25) / 51, (ONE_I + 26) / 52,
    (ONE_I + 26) / 53, (ONE_I + 27) / 54, (ONE_I + 27) / 55, (ONE_I + 28) / 56,
    (ONE_I + 28) / 57, (ONE_I + 29) / 58, (ONE_I + 29) / 59, (ONE_I + 30) / 60,
    (ONE_I + 30) / 61, (ONE_I + 31) / 62, (ONE_I + 31) / 63, (ONE_I + 32) / 64
  };

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_XX,
    OP_CHK_XX,
    OP_MUL_XP,
    OP_MAKE_T,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_UPD_P,
    OP_MAKE_NUM,
    OP_DIV,
    OP_WRITE_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic endpoint;
    logic order_one;
    logic last_step;
    logic div_last;
    logic out_free;
  } dp_sts_t;

endpackage

>>> rtl/core/lpe_ifs.sv
// Input channel: one evaluation point per item
interface lpe_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [lpe_pkg::X_W-1:0]  x_value;

  modport source (output valid, output x_value, input ready);
  modport sink   (input valid, input x_value, output ready);
endinterface

// Result channel: polynomial value, derivative and flags
interface lpe_res_if;
  logic                             valid;
  logic                             ready;
  logic signed [lpe_pkg::X_W-1:0]   p_value;
  logic signed [lpe_pkg::DP_W-1:0]  dp_value;
  logic                             deriv_saturated;
  logic                             endpoint_error;

  modport source (output valid, output p_value, output dp_value,
                  output deriv_saturated, output endpoint_error, input ready);
  modport sink   (input valid, input p_value, input dp_value,
                  input deriv_saturated, input endpoint_error, output ready);
endinterface

// Configuration write channel: polynomial order
interface lpe_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lpe_pkg::ORDER_W-1:0]       poly_order;

  modport source (output valid, output poly_order, input ready);
  modport sink   (input valid, input poly_order, output ready);
endinterface

>>> rtl/core/lpe_ctrl.sv
module lpe_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lpe_pkg::dp_sts_t sts_i,
  output lpe_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_XX,
    S_XX_CHK,
    S_MUL_XP,
    S_MAKE_T,
    S_MUL_LO,
    S_MUL_HI,
    S_UPD,
    S_FXP,
    S_NUM,
    S_DIV,
    S_DONE
  } state_e;

  state_e state_q;

  // Sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_XX;
          end
        end
        S_XX:     state_q <= S_XX_CHK;
        S_XX_CHK: state_q <= sts_i.order_one ? S_DONE : S_MUL_XP;
        S_MUL_XP: state_q <= S_MAKE_T;
        S_MAKE_T: state_q <= S_MUL_LO;
        S_MUL_LO: state_q <= S_MUL_HI;
        S_MUL_HI: state_q <= S_UPD;
        S_UPD: begin
          if (!sts_i.last_step) begin
            state_q <= S_MUL_XP;
          end else if (sts_i.endpoint) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_FXP;
          end
        end
        S_FXP: state_q <= S_NUM;
        S_NUM: state_q <= S_DIV;
        S_DIV: begin
          if (sts_i.div_last) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Command decode
  always_comb begin
    cmd_o.op   = lpe_pkg::OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = lpe_pkg::OP_LOAD;
        end
      end
      S_XX:     cmd_o.op = lpe_pkg::OP_MUL_XX;
      S_XX_CHK: cmd_o.op = lpe_pkg::OP_CHK_XX;
      S_MUL_XP: cmd_o.op = lpe_pkg::OP_MUL_XP;
      S_MAKE_T: cmd_o.op = lpe_pkg::OP_MAKE_T;
      S_MUL_LO: cmd_o.op = lpe_pkg::OP_MUL_LO;
      S_MUL_HI: cmd_o.op = lpe_pkg::OP_MUL_HI;
      S_UPD:    cmd_o.op = lpe_pkg::OP_UPD_P;
      S_FXP:    cmd_o.op = lpe_pkg::OP_MUL_XP;
      S_NUM:    cmd_o.op = lpe_pkg::OP_MAKE_NUM;
      S_DIV:    cmd_o.op = lpe_pkg::OP_DIV;
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.op = lpe_pkg::OP_WRITE_OUT;
        end
      end
      default: cmd_o.op = lpe_pkg::OP_NONE;
    endcase
  end

endmodule

>>> rtl/core/lpe_datapath.sv
module lpe_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lpe_pkg::dp_cmd_t                 cmd_i,
  output lpe_pkg::dp_sts_t                 sts_o,
  input  logic signed [lpe_pkg::X_W-1:0]   x_value_i,
  input  logic                             cfg_we_i,
  input  logic [lpe_pkg::ORDER_W-1:0]      poly_order_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic signed [lpe_pkg::X_W-1:0]   p_value_o,
  output logic signed [lpe_pkg::DP_W-1:0]  dp_value_o,
  output logic                             deriv_saturated_o,
  output logic                             endpoint_error_o
);

  localparam int FB    = lpe_pkg::FRAC_BITS;
  localparam int XW    = lpe_pkg::X_W;
  localparam int DW    = lpe_pkg::DP_W;
  localparam int OW    = lpe_pkg::ORDER_W;
  localparam int TW    = lpe_pkg::T_W;
  localparam int AW    = lpe_pkg::A_W;
  localparam int QW    = lpe_pkg::QUO_W;
  localparam int CW    = lpe_pkg::DIV_CNT_W;
  localparam int SUM_W = TW + FB + 1;

  localparam logic [63:0]      RND_HALF  = 64'(1) << (FB - 1);
  localparam logic [SUM_W-1:0] RND_HALFW = SUM_W'(1) << (FB - 1);
  localparam logic [QW-1:0]    DP_LIM    = QW'(1) << (DW - 1);

  // Configuration and registers
  logic [OW-1:0]          poly_order_q;
  logic signed [XW-1:0]   x_q, p_q, pp_q;
  logic [OW-1:0]          n_q, order_q;
  logic [63:0]            prod_q, acc_q;
  logic [TW-1:0]          t_mag_q;
  logic                   t_neg_q;
  logic                   endpoint_q;
  logic [FB:0]            b_q;
  logic                   dneg_q;
  logic [FB:0]            rem_q;
  logic [QW-1:0]          quo_q;
  logic [CW-1:0]          div_cnt_q;
  logic                   out_valid_q;
  logic signed [XW-1:0]   p_out_q;
  logic signed [DW-1:0]   dp_out_q;
  logic                   sat_out_q, ep_out_q;

  // Input clamp and effective order
  logic signed [XW-1:0]   x_clamp;
  logic [OW-1:0]          order_eff;

  always_comb begin
    if (x_value_i > lpe_pkg::ONE_X) begin
      x_clamp = lpe_pkg::ONE_X;
    end else if (x_value_i < -lpe_pkg::ONE_X) begin
      x_clamp = -lpe_pkg::ONE_X;
    end else begin
      x_clamp = x_value_i;
    end
    if (poly_order_q == '0) begin
      order_eff = OW'(1);
    end else if (poly_order_q > OW'(lpe_pkg::MAX_ORDER)) begin
      order_eff = OW'(lpe_pkg::MAX_ORDER);
    end else begin
      order_eff = poly_order_q;
    end
  end

  // Shared 32x32 magnitude multiplier
  logic [XW-1:0]  x_abs, p_abs, recip;
  logic [OW-1:0]  recip_idx;
  logic [XW-1:0]  mul_a, mul_b;
  logic [63:0]    mul_p;

  assign x_abs     = x_q[XW-1] ? XW'(-x_q) : XW'(x_q);
  assign p_abs     = p_q[XW-1] ? XW'(-p_q) : XW'(p_q);
  assign recip_idx = n_q + OW'(1);
  assign recip     = XW'(lpe_pkg::RECIP_TAB[recip_idx]);

  always_comb begin
    case (cmd_i.op)
      lpe_pkg::OP_MUL_XX: begin
        mul_a = x_abs;
        mul_b = x_abs;
      end
      lpe_pkg::OP_MUL_LO: begin
        mul_a = t_mag_q[XW-1:0];
        mul_b = recip;
      end
      lpe_pkg::OP_MUL_HI: begin
        mul_a = XW'(t_mag_q[TW-1:XW]);
        mul_b = recip;
      end
      default: begin
        mul_a = x_abs;
        mul_b = p_abs;
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Rounded product x*p (or x*x), ties away from zero
  logic [63:0]          rnd_sum;
  logic [FB:0]          rnd_mag;
  logic signed [XW-1:0] m_xp;

  assign rnd_sum = prod_q + RND_HALF;
  assign rnd_mag = rnd_sum[FB +: FB + 1];
  assign m_xp    = (x_q[XW-1] ^ p_q[XW-1]) ? -signed'(XW'(rnd_mag))
                                             : signed'(XW'(rnd_mag));

  // Bonnet term (2n+1)*x*p - n*p_prev
  logic signed [40:0] t_full;
  logic [TW-1:0]      t_mag;

  assign t_full = 41'(signed'({1'b0, n_q, 1'b1})) * 41'(m_xp)
                - 41'(signed'({1'b0, n_q})) * 41'(pp_q);
  assign t_mag  = TW'(t_full[40] ? -t_full : t_full);

  // Scale by 1/(n+1), round, clamp to [-1, 1]
  logic [SUM_W-1:0]     upd_sum;
  logic [SUM_W-FB-1:0]  upd_mag;
  logic [FB:0]          upd_clip;
  logic signed [XW-1:0] p_new;

  assign upd_sum  = SUM_W'(acc_q) + (SUM_W'(prod_q) << XW) + RND_HALFW;
  assign upd_mag  = upd_sum[SUM_W-1:FB];
  assign upd_clip = (upd_mag > (SUM_W - FB)'(lpe_pkg::ONE_MAG)) ? lpe_pkg::ONE_MAG
                                                                : upd_mag[FB:0];
  assign p_new    = t_neg_q ? -signed'(XW'(upd_clip)) : signed'(XW'(upd_clip));

  // Derivative numerator order*(x*p - p_prev)
  logic signed [XW:0]  diff;
  logic signed [40:0]  num;
  logic [AW-1:0]       num_mag;

  assign diff    = (XW + 1)'(m_xp) - (XW + 1)'(pp_q);
  assign num     = 41'(signed'({1'b0, order_q})) * 41'(diff);
  assign num_mag = AW'(num[40] ? -num : num);

  // One restoring division step
  logic [FB+1:0] r_sh, r_sub;
  logic          r_ge;
  logic [FB:0]   rem_d;

  assign r_sh  = {rem_q, quo_q[QW-1]};
  assign r_ge  = r_sh >= {1'b0, b_q};
  assign r_sub = r_sh - {1'b0, b_q};
  assign rem_d = r_ge ? r_sub[FB:0] : r_sh[FB:0];

  // Final rounding and saturation of the quotient
  logic [QW-1:0]        q_rnd;
  logic                 q_sat;
  logic [DW-1:0]        dp_mag;
  logic signed [DW-1:0] dp_div, dp_fin;
  logic                 sat_fin;

  assign q_rnd  = QW'((QW + 1)'(quo_q) + (QW + 1)'(1) >> 1);
  assign q_sat  = dneg_q ? (q_rnd > DP_LIM) : (q_rnd > DP_LIM - QW'(1));
  assign dp_mag = q_sat ? (dneg_q ? DW'(DP_LIM) : DW'(DP_LIM - QW'(1))) : DW'(q_rnd);
  assign dp_div = dneg_q ? -signed'(dp_mag) : signed'(dp_mag);

  always_comb begin
    if (endpoint_q) begin
      dp_fin  = '0;
      sat_fin = 1'b0;
    end else if (order_q == OW'(1)) begin
      dp_fin  = DW'(lpe_pkg::ONE_X);
      sat_fin = 1'b0;
    end else begin
      dp_fin  = dp_div;
      sat_fin = q_sat;
    end
  end

  // Status to the controller
  assign sts_o.endpoint  = endpoint_q;
  assign sts_o.order_one = (order_q == OW'(1));
  assign sts_o.last_step = (recip_idx == order_q);
  assign sts_o.div_last  = (div_cnt_q == CW'(QW - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_order_q <= OW'(1);
      out_valid_q  <= 1'b0;
      endpoint_q   <= 1'b0;
      n_q          <= '0;
      order_q      <= OW'(1);
      div_cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        poly_order_q <= poly_order_i;
      end
      if (cmd_i.op == lpe_pkg::OP_WRITE_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        lpe_pkg::OP_LOAD: begin
          n_q     <= OW'(1);
          order_q <= order_eff;
        end
        lpe_pkg::OP_CHK_XX:   endpoint_q <= (rnd_mag == lpe_pkg::ONE_MAG);
        lpe_pkg::OP_UPD_P:    n_q        <= recip_idx;
        lpe_pkg::OP_MAKE_NUM: div_cnt_q  <= '0;
        lpe_pkg::OP_DIV:      div_cnt_q  <= div_cnt_q + CW'(1);
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      lpe_pkg::OP_LOAD: begin
        x_q  <= x_clamp;
        p_q  <= x_clamp;
        pp_q <= lpe_pkg::ONE_X;
      end
      lpe_pkg::OP_MUL_XX: prod_q <= mul_p;
      lpe_pkg::OP_CHK_XX: b_q    <= lpe_pkg::ONE_MAG - rnd_mag;
      lpe_pkg::OP_MUL_XP: prod_q <= mul_p;
      lpe_pkg::OP_MAKE_T: begin
        t_mag_q <= t_mag;
        t_neg_q <= t_full[40];
      end
      lpe_pkg::OP_MUL_LO: prod_q <= mul_p;
      lpe_pkg::OP_MUL_HI: begin
        acc_q  <= prod_q;
        prod_q <= mul_p;
      end
      lpe_pkg::OP_UPD_P: begin
        pp_q <= p_q;
        p_q  <= p_new;
      end
      lpe_pkg::OP_MAKE_NUM: begin
        // denominator x^2-1 is negative, so the sign flips
        dneg_q <= !num[40];
        rem_q  <= '0;
        quo_q  <= {num_mag, (FB + 1)'(0)};
      end
      lpe_pkg::OP_DIV: begin
        rem_q <= rem_d;
        quo_q <= {quo_q[QW-2:0], r_ge};
      end
      lpe_pkg::OP_WRITE_OUT: begin
        p_out_q   <= p_q;
        dp_out_q  <= dp_fin;
        sat_out_q <= sat_fin;
        ep_out_q  <= endpoint_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign p_value_o         = p_out_q;
  assign dp_value_o        = dp_out_q;
  assign deriv_saturated_o = sat_out_q;
  assign endpoint_error_o  = ep_out_q;

endmodule

>>> rtl/core/legendre_polynomial_eval_core.sv
// Evaluates the Legendre polynomial P_N(x) and its derivative P'_N(x) for one
// signed Q1.30 point per item, N taken from the poly_order register (0 acts as
// 1, values above 64 act as 64); points outside [-1, 1] are clamped. P comes
// from the Bonnet three-term recurrence, each step rounded and clamped to
// [-1, 1]; the derivative N(xP_N - P_{N-1})/(x^2-1) is a Q12.30 value with
// saturation flagged. At |x| = 1 (or when x^2 rounds to 1) endpoint_error is
// set and the derivative is 0. Items are handled one at a time: each recurrence
// step passes through the x*p product, the Bonnet term, the low and high
// products with 1/(n+1) and the update on the one shared 32x32 multiplier;
// items with N >= 2 off the endpoints then go through the radix-2 restoring
// divider. A finished result sits in an output register, so the next item is
// taken while it waits.
module legendre_polynomial_eval_core (
  input logic        clk_i,
  input logic        rst_ni,
  lpe_in_if.sink     in_i,
  lpe_cfg_if.sink    cfg_i,
  lpe_res_if.source  res_o
);

  lpe_pkg::dp_cmd_t dp_cmd;
  lpe_pkg::dp_sts_t dp_sts;
  logic             in_ready;

  // Sequencer
  lpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  // Arithmetic, order register and output register
  lpe_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (dp_cmd),
    .sts_o             (dp_sts),
    .x_value_i         (in_i.x_value),
    .cfg_we_i          (cfg_i.valid),
    .poly_order_i      (cfg_i.poly_order),
    .out_ready_i       (res_o.ready),
    .out_valid_o       (res_o.valid),
    .p_value_o         (res_o.p_value),
    .dp_value_o        (res_o.dp_value),
    .deriv_saturated_o (res_o.deriv_saturated),
    .endpoint_error_o  (res_o.endpoint_error)
  );

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  // An accepted item starts with the x*x product
  a_load_then_square: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (dp_cmd.op == lpe_pkg::OP_MUL_XX))
    else $error("accepted item not followed by x*x product");

  // A result is only written when the output register can take it
  a_write_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_cmd.op == lpe_pkg::OP_WRITE_OUT) |-> dp_sts.out_free)
    else $error("result written over a pending result");

  // Endpoint results carry a zero, unsaturated derivative
  a_endpoint_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.endpoint_error) |->
      (res_o.dp_value == '0 && !res_o.deriv_saturated))
    else $error("endpoint result with nonzero derivative");

  // P stays within [-1, 1]
  a_p_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |->
      (res_o.p_value <= lpe_pkg::ONE_X && res_o.p_value >= -lpe_pkg::ONE_X))
    else $error("p_value outside [-1, 1]");

endmodule
